>>> rtl/stg_pkg.sv
// ============================================================================
// stg_pkg
// Shared types, constants and the quarter-wave sine table of the tone
// generator.
// ============================================================================
`default_nettype none

package stg_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int QTR_W        = IDX_W - 2;
    localparam int QUARTER      = SINE_ENTRIES / 4;

    localparam int STEP_W = 31;
    localparam int LEN_W  = 24;
    localparam int PHASE_W = 32;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W = 15;

    localparam logic [STEP_W-1:0] PHASE_STEP_RESET  = 31'd42852281;
    localparam logic [LEN_W-1:0]  TONE_LENGTH_RESET = 24'd44100;

    localparam logic REG_PHASE_STEP  = 1'b0;
    localparam logic REG_TONE_LENGTH = 1'b1;

    localparam logic [63:0] AMPLITUDE   = 64'd32767;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] LOW32       = 64'hFFFFFFFF;

    typedef struct packed {
        logic             active;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tick_t;

    typedef logic [MAG_W-1:0] qtab_t [QUARTER];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] hh;
        logic [63:0] hl;
        logic [63:0] lh;
        logic [63:0] ll;
        logic [63:0] mid;
        logic [63:0] lo;
        logic [63:0] hi;
        ah  = a >> 32;
        al  = a & LOW32;
        bh  = b >> 32;
        bl  = b & LOW32;
        hh  = ah * bh;
        hl  = ah * bl;
        lh  = al * bh;
        ll  = al * bl;
        mid = (ll >> 32) + (hl & LOW32) + (lh & LOW32);
        lo  = (ll & LOW32) | (mid << 32);
        hi  = hh + (hl >> 32) + (lh >> 32) + (mid >> 32);
        return (hi << 2) | (lo >> 62);
    endfunction

    // Magnitude of the first quadrant at quarter index j, by a Taylor series
    // in Q62 fixed point.
    function automatic logic [63:0] sine_mag(input int j);
        logic [63:0] r;
        logic [63:0] theta;
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        int          i;
        r = 64'(j) * 64'd4;
        if (r == 64'd0)
        begin
            mag = 64'd0;
        end
        else
        begin
            theta = (HALF_PI_Q62 / SINE_ENTRIES) * r
                  + ((HALF_PI_Q62 % SINE_ENTRIES) * r) / SINE_ENTRIES;
            sq   = mul_q62(theta, theta);
            term = theta;
            sum  = theta;
            for (i = 1; i < 40 && term != 64'd0; i++)
            begin
                term = mul_q62(term, sq) / 64'((2 * i) * (2 * i + 1));
                if ((i % 2) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            mag = mul_q62(AMPLITUDE, sum);
            if (mag > AMPLITUDE)
                mag = AMPLITUDE;
        end
        return mag;
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int j = 0; j < QUARTER; j++)
        begin
            tab[j] = MAG_W'(sine_mag(j));
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

>>> rtl/stg_front.sv
// ============================================================================
// stg_front
// Holds the configuration registers and the phase accumulator, takes one
// request per tick and classifies it into a table index and flags.
// ============================================================================
`default_nettype none

module stg_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [stg_pkg::STEP_W-1:0]  cfg_wdata,
    input  wire logic                        accept,
    input  wire logic                        restart,
    output stg_pkg::tick_t                   tick
);

    logic [stg_pkg::STEP_W-1:0]  phase_step_reg;
    logic [stg_pkg::LEN_W-1:0]   tone_length_reg;
    logic [stg_pkg::PHASE_W-1:0] phase_reg;
    logic [stg_pkg::PHASE_W-1:0] phase_next;
    logic [stg_pkg::LEN_W-1:0]   sidx_reg;
    logic [stg_pkg::LEN_W-1:0]   sidx_next;
    logic                        running_reg;
    logic                        running_next;

    logic [stg_pkg::PHASE_W-1:0] phase_eff;
    logic [stg_pkg::LEN_W-1:0]   sidx_eff;
    logic                        run_eff;
    logic                        is_last;

    always_comb
    begin
        phase_eff = restart ? '0 : phase_reg;
        sidx_eff  = restart ? '0 : sidx_reg;
        run_eff   = restart ? (tone_length_reg != '0) : running_reg;
        is_last   = ({1'b0, sidx_eff} + (stg_pkg::LEN_W + 1)'(1))
                    >= {1'b0, tone_length_reg};

        tick.active = run_eff;
        tick.last   = run_eff && is_last;
        tick.idx    = phase_eff[stg_pkg::PHASE_W-1 -: stg_pkg::IDX_W];

        phase_next   = phase_eff;
        sidx_next    = sidx_eff;
        running_next = run_eff;
        if (run_eff)
        begin
            phase_next   = phase_eff + {1'b0, phase_step_reg};
            sidx_next    = sidx_eff + stg_pkg::LEN_W'(1);
            running_next = !is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= stg_pkg::PHASE_STEP_RESET;
            tone_length_reg <= stg_pkg::TONE_LENGTH_RESET;
            phase_reg       <= '0;
            sidx_reg        <= '0;
            running_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    stg_pkg::REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata;
                    stg_pkg::REG_TONE_LENGTH: tone_length_reg <= cfg_wdata[stg_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                sidx_reg    <= sidx_next;
                running_reg <= running_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/stg_queue.sv
// ============================================================================
// stg_queue
// Short first-in first-out queue of classified ticks between the front and
// the back.
// ============================================================================
`default_nettype none

module stg_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire stg_pkg::tick_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output stg_pkg::tick_t      head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    stg_pkg::tick_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full  = (count_reg == FULL_COUNT);
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/stg_back.sv
// ============================================================================
// stg_back
// Looks up the quarter-wave table, restores the sign from the quadrant and
// holds the result in the output register.
// ============================================================================
`default_nettype none

module stg_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire stg_pkg::tick_t                q_head,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [stg_pkg::SAMPLE_W-1:0]       out_sample,
    output logic                               out_active,
    output logic                               out_last
);

    logic                            valid_reg;
    logic [stg_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [stg_pkg::SAMPLE_W-1:0]    sample_next;
    logic                            active_reg;
    logic                            last_reg;

    logic [1:0]                      quad;
    logic [stg_pkg::QTR_W-1:0]       qidx;
    logic [stg_pkg::QTR_W:0]         mirror;
    logic [stg_pkg::SAMPLE_W-1:0]    mag;

    assign q_pop      = q_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_active = active_reg;
    assign out_last   = last_reg;

    always_comb
    begin
        quad = q_head.idx[stg_pkg::IDX_W-1 -: 2];
        qidx = q_head.idx[stg_pkg::QTR_W-1:0];
        if (quad[0])
            mirror = (stg_pkg::QTR_W + 1)'(stg_pkg::QUARTER) - {1'b0, qidx};
        else
            mirror = {1'b0, qidx};
        if (mirror[stg_pkg::QTR_W])
            mag = stg_pkg::SAMPLE_W'(stg_pkg::AMPLITUDE);
        else
            mag = {1'b0, stg_pkg::QTAB[mirror[stg_pkg::QTR_W-1:0]]};
        if (!q_head.active)
            sample_next = '0;
        else if (quad[1])
            sample_next = -mag;
        else
            sample_next = mag;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg <= sample_next;
            active_reg <= q_head.active;
            last_reg   <= q_head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

endmodule

`default_nettype wire

>>> rtl/sine_tone_generator.sv
// Each accepted request is written into the queue; its sample is then looked
// up from the queue head and held in the output register until it is taken.
// Throughput: one request per cycle while the queue is not full.
// A queue, two entries by default, parts the accumulator from table lookup
// and output. Reset clears the phase, the sample count and the running flag,
// and loads the phase step with 42852281 and the length with 44100 samples.
// ============================================================================
// sine_tone_generator
// Direct digital synthesis sine oscillator with a restartable tone of
// configurable length.
// ============================================================================
`default_nettype none

module sine_tone_generator
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample
    output logic             m_axis_tuser,   // [0] active
    output logic             m_axis_tlast
);

    logic           accept;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    stg_pkg::tick_t tick;
    stg_pkg::tick_t q_head;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    stg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .restart   (s_axis_tdata[0]),
        .tick      (tick)
    );

    stg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (tick),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    stg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata),
        .out_active (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire
